[src/chm_pkg.sv]
package chm_pkg;

	// Default sizes, handed to the top level as parameter defaults.
	localparam int unsigned DEF_NUM_BUCKETS = 16;
	localparam int unsigned DEF_CAPACITY    = 256;
	localparam int unsigned DEF_KEY_BITS    = 32;
	localparam int unsigned DEF_VALUE_BITS  = 32;

	localparam int unsigned OP_W     = 2;
	localparam int unsigned STATUS_W = 3;

	// Request opcodes. The unused code behaves as a find.
	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 2'd0,
		OP_FIND   = 2'd1,
		OP_CLEAR  = 2'd2
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_UPDATED   = 3'd0,
		STS_INSERTED  = 3'd1,
		STS_FULL      = 3'd2,
		STS_FOUND     = 3'd3,
		STS_NOT_FOUND = 3'd4,
		STS_CLEARED   = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_HEAD,
		S_WALK,
		S_DONE
	} state_t;

	// Read and write strobes from the control logic to the table storage.
	typedef struct packed {
		logic hd_rd;
		logic hd_we;
		logic en_rd;
		logic en_we;
	} mem_ctrl_t;

endpackage

[src/chained_hash_map_top.sv]
// A request passes through S_HEAD, then S_WALK once per chain entry visited, where the
// entry memory is read, then S_DONE, where its result waits for the output register; a
// clear, or a request whose bucket is empty, goes from S_HEAD straight to S_DONE. One
// request is handled at a time; the next is accepted once the last has left S_DONE.
// Reset clears the bucket valid bits, the entry count and the control state; the
// memories are not swept, since an entry is always written before it is reachable.
module chained_hash_map_top #(
	parameter int unsigned NUM_BUCKETS = chm_pkg::DEF_NUM_BUCKETS,
	parameter int unsigned CAPACITY    = chm_pkg::DEF_CAPACITY,
	parameter int unsigned KEY_BITS    = chm_pkg::DEF_KEY_BITS,
	parameter int unsigned VALUE_BITS  = chm_pkg::DEF_VALUE_BITS,
	localparam int unsigned CNT_W      = $clog2(CAPACITY + 1)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [chm_pkg::OP_W-1:0]     op,
	input  logic [KEY_BITS-1:0]          key,
	input  logic [VALUE_BITS-1:0]        value,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [chm_pkg::STATUS_W-1:0] status,
	output logic [VALUE_BITS-1:0]        value_out,
	output logic [CNT_W-1:0]             entry_count
);

	localparam int unsigned BKT_W = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
	localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	// Control state.
	chm_pkg::state_t          state_q, state_d;
	logic [NUM_BUCKETS-1:0]   bvalid_q;
	logic [CNT_W-1:0]         count_q;
	logic                     out_valid_q;

	// The request being worked on.
	logic [chm_pkg::OP_W-1:0] op_q;
	logic [KEY_BITS-1:0]      key_q;
	logic [VALUE_BITS-1:0]    value_q;
	logic [BKT_W-1:0]         bkt_q;
	logic [IDX_W-1:0]         head_q;
	logic [IDX_W-1:0]         cur_idx_q;

	// Result waiting for the output register, and the output register itself.
	chm_pkg::status_t         res_status_q, res_status_d;
	logic [VALUE_BITS-1:0]    res_value_q, res_value_d;
	chm_pkg::status_t         out_status_q;
	logic [VALUE_BITS-1:0]    out_value_q;
	logic [CNT_W-1:0]         out_count_q;

	// Strobes from the next-state logic.
	logic                     accept;
	logic                     res_ld;
	logic                     load_out;
	logic                     clr;
	logic                     ins;
	logic                     miss;
	logic                     hd_ld;
	logic                     cur_ld;
	logic [IDX_W-1:0]         cur_d;
	logic                     full;

	// The bucket is the low bits of the key, zero-extended for narrow keys.
	logic [KEY_BITS+BKT_W-1:0] key_ext;
	logic [BKT_W-1:0]          key_bkt;

	// Storage interface.
	chm_pkg::mem_ctrl_t       ctrl;
	logic [IDX_W-1:0]         hd_rd_data;
	logic [IDX_W-1:0]         en_rd_addr;
	logic [KEY_BITS-1:0]      en_rd_key;
	logic [VALUE_BITS-1:0]    en_rd_value;
	logic                     en_rd_link_vld;
	logic [IDX_W-1:0]         en_rd_link;
	logic [IDX_W-1:0]         en_wr_addr;
	logic                     en_wr_link_vld;
	logic [IDX_W-1:0]         en_wr_link;

	assign key_ext = (KEY_BITS+BKT_W)'(key);
	assign key_bkt = key_ext[BKT_W-1:0];

	// A request is taken only while no other one is in flight. The output register
	// holds the previous result, so a new request can start while it waits.
	assign in_stall = (state_q != chm_pkg::S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign full     = (count_q == CNT_W'(CAPACITY));

	chm_store #(
		.NUM_BUCKETS (NUM_BUCKETS),
		.CAPACITY    (CAPACITY),
		.KEY_BITS    (KEY_BITS),
		.VALUE_BITS  (VALUE_BITS)
	) u_store (
		.clk            (clk),
		.ctrl           (ctrl),
		.hd_rd_addr     (key_bkt),
		.hd_rd_data     (hd_rd_data),
		.hd_wr_addr     (bkt_q),
		.hd_wr_data     (count_q[IDX_W-1:0]),
		.en_rd_addr     (en_rd_addr),
		.en_rd_key      (en_rd_key),
		.en_rd_value    (en_rd_value),
		.en_rd_link_vld (en_rd_link_vld),
		.en_rd_link     (en_rd_link),
		.en_wr_addr     (en_wr_addr),
		.en_wr_key      (key_q),
		.en_wr_value    (value_q),
		.en_wr_link_vld (en_wr_link_vld),
		.en_wr_link     (en_wr_link)
	);

	// Next state and datapath control. The head read is issued with the request; in
	// S_HEAD a clear empties the table, else the bucket is either empty or its first entry
	// is read. Each cycle in S_WALK compares one entry and, on a mismatch, follows its link.
	// Unless the table is full, a new key is written at the next free entry and pushed at the head of its bucket.
	always_comb begin
		state_d        = state_q;
		ctrl           = '0;
		en_rd_addr     = hd_rd_data;
		en_wr_addr     = cur_idx_q;
		en_wr_link_vld = en_rd_link_vld;
		en_wr_link     = en_rd_link;
		res_status_d   = chm_pkg::STS_NOT_FOUND;
		res_value_d    = '0;
		res_ld         = 1'b0;
		load_out       = 1'b0;
		clr            = 1'b0;
		ins            = 1'b0;
		miss           = 1'b0;
		hd_ld          = 1'b0;
		cur_ld         = 1'b0;
		cur_d          = hd_rd_data;

		unique case (state_q)
			chm_pkg::S_IDLE: begin
				if (in_valid) begin
					ctrl.hd_rd = 1'b1;
					state_d    = chm_pkg::S_HEAD;
				end
			end
			chm_pkg::S_HEAD: begin
				hd_ld = 1'b1;
				if (op_q == chm_pkg::OP_CLEAR) begin
					clr          = 1'b1;
					res_status_d = chm_pkg::STS_CLEARED;
					res_ld       = 1'b1;
					state_d      = chm_pkg::S_DONE;
				end else if (bvalid_q[bkt_q]) begin
					ctrl.en_rd = 1'b1;
					en_rd_addr = hd_rd_data;
					cur_ld     = 1'b1;
					cur_d      = hd_rd_data;
					state_d    = chm_pkg::S_WALK;
				end else begin
					miss = 1'b1;
				end
			end
			chm_pkg::S_WALK: begin
				if (en_rd_key == key_q) begin
					res_ld  = 1'b1;
					state_d = chm_pkg::S_DONE;
					if (op_q == chm_pkg::OP_INSERT) begin
						// Rewrite the entry in place, keeping its key and link.
						ctrl.en_we   = 1'b1;
						en_wr_addr   = cur_idx_q;
						res_status_d = chm_pkg::STS_UPDATED;
					end else begin
						res_status_d = chm_pkg::STS_FOUND;
						res_value_d  = en_rd_value;
					end
				end else if (en_rd_link_vld) begin
					ctrl.en_rd = 1'b1;
					en_rd_addr = en_rd_link;
					cur_ld     = 1'b1;
					cur_d      = en_rd_link;
				end else begin
					miss = 1'b1;
				end
			end
			chm_pkg::S_DONE: begin
				if (!out_valid_q || !out_stall) begin
					load_out = 1'b1;
					state_d  = chm_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = chm_pkg::S_IDLE;
			end
		endcase

		// The key is not on its chain.
		if (miss) begin
			res_ld  = 1'b1;
			state_d = chm_pkg::S_DONE;
			if (op_q == chm_pkg::OP_INSERT) begin
				if (full) begin
					res_status_d = chm_pkg::STS_FULL;
				end else begin
					ins            = 1'b1;
					ctrl.en_we     = 1'b1;
					ctrl.hd_we     = 1'b1;
					en_wr_addr     = count_q[IDX_W-1:0];
					en_wr_link_vld = bvalid_q[bkt_q];
					en_wr_link     = (state_q == chm_pkg::S_HEAD) ? hd_rd_data : head_q;
					res_status_d   = chm_pkg::STS_INSERTED;
				end
			end else begin
				res_status_d = chm_pkg::STS_NOT_FOUND;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= chm_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Bucket valid bits and the entry count; the count also names the next free entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bvalid_q <= '0;
			count_q  <= '0;
		end else if (clr) begin
			bvalid_q <= '0;
			count_q  <= '0;
		end else if (ins) begin
			bvalid_q[bkt_q] <= 1'b1;
			count_q         <= count_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= op;
			key_q   <= key;
			value_q <= value;
			bkt_q   <= key_bkt;
		end
		if (hd_ld) begin
			head_q <= hd_rd_data;
		end
		if (cur_ld) begin
			cur_idx_q <= cur_d;
		end
		if (res_ld) begin
			res_status_q <= res_status_d;
			res_value_q  <= res_value_d;
		end
		if (load_out) begin
			out_status_q <= res_status_q;
			out_value_q  <= res_value_q;
			out_count_q  <= count_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = out_status_q;
	assign value_out   = out_value_q;
	assign entry_count = out_count_q;

	// The entry count never passes the capacity.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	// Entries are written only inside the used region or at the next free slot.
	a_write_in_use: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.en_we |-> (CNT_W'(en_wr_addr) <= count_q) && !(ins && full))
		else $error("entry write outside the allocated range");

	// A clear always reports an empty table.
	a_clear_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == chm_pkg::STS_CLEARED) |-> (entry_count == '0))
		else $error("clear result with nonzero count");

	// Only a find hit carries a value.
	a_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != chm_pkg::STS_FOUND) |-> (value_out == '0))
		else $error("value on a result that is not a find hit");

	// A key can be found or updated only in a table that holds entries.
	a_hit_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ((status == chm_pkg::STS_FOUND) || (status == chm_pkg::STS_UPDATED))
		|-> (entry_count != '0))
		else $error("hit reported on an empty table");

endmodule

[src/chm_store.sv]
// Table storage: the bucket head memory and the entry memory. Both are
// synchronous, with read data registered and valid in the cycle after the read strobe.
module chm_store #(
	parameter int unsigned NUM_BUCKETS = chm_pkg::DEF_NUM_BUCKETS,
	parameter int unsigned CAPACITY    = chm_pkg::DEF_CAPACITY,
	parameter int unsigned KEY_BITS    = chm_pkg::DEF_KEY_BITS,
	parameter int unsigned VALUE_BITS  = chm_pkg::DEF_VALUE_BITS,
	localparam int unsigned BKT_W      = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1,
	localparam int unsigned IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
	input  logic                  clk,
	input  chm_pkg::mem_ctrl_t    ctrl,
	input  logic [BKT_W-1:0]      hd_rd_addr,
	output logic [IDX_W-1:0]      hd_rd_data,
	input  logic [BKT_W-1:0]      hd_wr_addr,
	input  logic [IDX_W-1:0]      hd_wr_data,
	input  logic [IDX_W-1:0]      en_rd_addr,
	output logic [KEY_BITS-1:0]   en_rd_key,
	output logic [VALUE_BITS-1:0] en_rd_value,
	output logic                  en_rd_link_vld,
	output logic [IDX_W-1:0]      en_rd_link,
	input  logic [IDX_W-1:0]      en_wr_addr,
	input  logic [KEY_BITS-1:0]   en_wr_key,
	input  logic [VALUE_BITS-1:0] en_wr_value,
	input  logic                  en_wr_link_vld,
	input  logic [IDX_W-1:0]      en_wr_link
);

	localparam int unsigned ENT_W = KEY_BITS + VALUE_BITS + 1 + IDX_W;

	logic [IDX_W-1:0] head_mem [NUM_BUCKETS];
	logic [ENT_W-1:0] entry_mem [CAPACITY];
	logic [ENT_W-1:0] en_rd_word_q;

	always_ff @(posedge clk) begin
		if (ctrl.hd_we) begin
			head_mem[hd_wr_addr] <= hd_wr_data;
		end
		if (ctrl.hd_rd) begin
			hd_rd_data <= head_mem[hd_rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.en_we) begin
			entry_mem[en_wr_addr] <= {en_wr_link_vld, en_wr_link, en_wr_value, en_wr_key};
		end
		if (ctrl.en_rd) begin
			en_rd_word_q <= entry_mem[en_rd_addr];
		end
	end

	assign en_rd_key      = en_rd_word_q[KEY_BITS-1:0];
	assign en_rd_value    = en_rd_word_q[KEY_BITS +: VALUE_BITS];
	assign en_rd_link     = en_rd_word_q[KEY_BITS+VALUE_BITS +: IDX_W];
	assign en_rd_link_vld = en_rd_word_q[ENT_W-1];

endmodule
